FILE: rtl/tlg_pkg.sv
package tlg_pkg;

  // board limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // field and register widths
  localparam int ROW_W   = 64;
  localparam int CFG_W   = 7;
  localparam int OP_W    = 2;
  localparam int ROW_AW  = $clog2(MAX_HEIGHT);
  localparam int COL_AW  = $clog2(MAX_WIDTH);
  localparam int CNT_W   = ROW_AW + 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [ROW_W-1:0] row_t;

  // ones in the n lowest bits, n from 1 to ROW_W
  function automatic row_t low_mask(input logic [CFG_W-1:0] n);
    row_t m;
    m = ~row_t'(0);
    return m >> (CFG_W'(ROW_W) - n);
  endfunction

  // zero acts as one, above the limit acts as the limit
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] top);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

FILE: rtl/tlg_ram.sv
module tlg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tlg_row_rule.sv
module tlg_row_rule import tlg_pkg::*; (
  input  row_t             up_row,
  input  row_t             cur_row,
  input  row_t             dn_row,
  input  logic [CFG_W-1:0] width_use,
  output row_t             next_row
);

  logic [CFG_W-1:0]  wm1_full;
  logic [COL_AW-1:0] wm1;
  row_t up_l, up_r, cur_l, cur_r, dn_l, dn_r, raw;

  assign wm1_full = width_use - CFG_W'(1);
  assign wm1      = wm1_full[COL_AW-1:0];

  // left neighbour vector, column 0 wraps to the last column in use
  function automatic row_t left_of(input row_t r, input logic [COL_AW-1:0] last);
    row_t v;
    v = r << 1;
    v[0] = r[last];
    return v;
  endfunction

  // right neighbour vector, the last column in use wraps to column 0
  function automatic row_t right_of(input row_t r, input logic [COL_AW-1:0] last);
    row_t v;
    v = r >> 1;
    for (int c = 0; c < ROW_W; c++) begin
      if (COL_AW'(c) == last) v[c] = r[0];
    end
    return v;
  endfunction

  assign up_l  = left_of(up_row, wm1);
  assign up_r  = right_of(up_row, wm1);
  assign cur_l = left_of(cur_row, wm1);
  assign cur_r = right_of(cur_row, wm1);
  assign dn_l  = left_of(dn_row, wm1);
  assign dn_r  = right_of(dn_row, wm1);

  // count eight neighbours per column and apply birth on three, survival on two or three
  always_comb begin
    logic [3:0] n;
    raw = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = {3'b0, up_l[c]} + {3'b0, up_row[c]} + {3'b0, up_r[c]}
        + {3'b0, cur_l[c]} + {3'b0, cur_r[c]}
        + {3'b0, dn_l[c]} + {3'b0, dn_row[c]} + {3'b0, dn_r[c]};
      raw[c] = (n == 4'd3) || (cur_row[c] && (n == 4'd2));
    end
  end

  assign next_row = raw & low_mask(width_use);

endmodule

FILE: rtl/toroidal_life_generation.sv
// channel | signals                                   | handshake
// --------+-------------------------------------------+-----------------------------
// item in | start, op, row_index, row_cells           | taken when start && !busy
// result  | done, read_cells, index_error             | one-cycle strobe on done
// config  | cfg_valid, cfg_index, cfg_data, cfg_ready | written when valid && ready
//
// write, bad-index and unused items: result in the cycle after the item is taken
// read: the board memory read, then the row is registered
// advance: one memory read per row plus the wrapped top row,
// then the last two rows go through the rule and are written back
// rst is synchronous; it clears the row valid bits, so the board reads as dead
// results cannot be held off; busy covers read and advance items still in progress
module toroidal_life_generation import tlg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [ROW_AW-1:0] row_index,
  input  row_t              row_cells,
  output logic              done,
  output row_t              read_cells,
  output logic              index_error,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;
  localparam logic [1:0] ST_LAST = 2'd3;

  logic [1:0]        state;
  logic [CFG_W-1:0]  board_width, board_height;
  logic [CFG_W-1:0]  w_use, h_use, h_m1;
  logic [CNT_W-1:0]  issue_k, pend_k, issue_m1, pend_m2;
  logic              pend;
  logic              accept, idx_ok, issue_now;
  logic [MAX_HEIGHT-1:0] row_valid;
  logic              rd_valid;
  row_t              ram_q, rd_row;
  row_t              up_row, cur_row, row0_save, rule_dn, rule_out;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  row_t              ram_wdata;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // sizes in use
  assign w_use    = clamp_size(board_width, CFG_W'(MAX_WIDTH));
  assign h_use    = clamp_size(board_height, CFG_W'(MAX_HEIGHT));
  assign h_m1     = h_use - CFG_W'(1);
  assign idx_ok   = {1'b0, row_index} < h_use;
  assign issue_m1 = issue_k - CNT_W'(1);
  assign pend_m2  = pend_k - CNT_W'(2);
  assign issue_now = (state == ST_GEN) && (issue_k <= CNT_W'(h_use));

  // rows never written read as dead
  assign rd_row = rd_valid ? ram_q : '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= CFG_W'(MAX_WIDTH);
      board_height <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) board_width <= cfg_data;
      if (cfg_index == CFG_HEIGHT) board_height <= cfg_data;
    end
  end

  // read address: wrapped top row first, then rows from zero up
  always_comb begin
    ram_raddr = row_index;
    if (state == ST_GEN) begin
      if (issue_k == '0) ram_raddr = h_m1[ROW_AW-1:0];
      else ram_raddr = issue_m1[ROW_AW-1:0];
    end
  end

  // write port: item writes, generation rows, then the last row
  assign rule_dn = (state == ST_LAST) ? row0_save : rd_row;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_index;
    ram_wdata = row_cells;
    if (state == ST_IDLE) begin
      ram_we = accept && (op == OP_WRITE) && idx_ok;
    end else if (state == ST_GEN) begin
      ram_we    = pend && (pend_k >= CNT_W'(2));
      ram_waddr = pend_m2[ROW_AW-1:0];
      ram_wdata = rule_out;
    end else if (state == ST_LAST) begin
      ram_we    = 1'b1;
      ram_waddr = h_m1[ROW_AW-1:0];
      ram_wdata = rule_out;
    end
  end

  tlg_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_HEIGHT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  tlg_row_rule u_rule (
    .up_row   (up_row),
    .cur_row  (cur_row),
    .dn_row   (rule_dn),
    .width_use(w_use),
    .next_row (rule_out)
  );

  // row valid bits, read alongside the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= row_valid[ram_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      pend    <= 1'b0;
      issue_k <= '0;
      pend_k  <= '0;
    end else begin
      pend <= issue_now;
      if (issue_now) begin
        pend_k  <= issue_k;
        issue_k <= issue_k + CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          done <= accept && (op != OP_ADVANCE) && !((op == OP_READ) && idx_ok);
          if (accept) begin
            issue_k <= '0;
            if (op == OP_ADVANCE) state <= ST_GEN;
            else if (op == OP_READ && idx_ok) state <= ST_READ;
          end
        end
        ST_READ: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_GEN: begin
          done <= 1'b0;
          if (pend && (pend_k == CNT_W'(h_use))) state <= ST_LAST;
        end
        ST_LAST: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // row window for the generation walk
  always_ff @(posedge clk) begin
    if (state == ST_GEN && pend) begin
      if (pend_k == '0) begin
        up_row <= rd_row;
      end else if (pend_k == CNT_W'(1)) begin
        cur_row   <= rd_row;
        row0_save <= rd_row;
      end else begin
        up_row  <= cur_row;
        cur_row <= rd_row;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      read_cells  <= '0;
      index_error <= !idx_ok && ((op == OP_WRITE) || (op == OP_READ));
    end else if (state == ST_READ) begin
      read_cells  <= rd_row & low_mask(w_use);
      index_error <= 1'b0;
    end else if (state == ST_LAST) begin
      read_cells  <= '0;
      index_error <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(state == ST_READ) || $past(state == ST_LAST)))
    else $error("result strobe without a finished item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (read_cells == '0))
    else $error("index error with non-zero row data");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !ram_we)
    else $error("board write during a row read");

  a_gen_addr: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == ST_GEN || state == ST_LAST)) |-> ({1'b0, ram_waddr} < h_use))
    else $error("generation write beyond the height in use");
`endif

endmodule
